// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the auto range scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/ars_pkg.sv =====
// Types and constants shared by the auto range scaler modules.
`default_nettype none

package ars_pkg;

	localparam int DATA_WIDTH = 32;

	// APB data path and register spacing
	localparam int APB_DW   = (DATA_WIDTH > 32) ? 64 : 32;
	localparam int ADDR_LSB = (DATA_WIDTH > 32) ? 3 : 2;
	localparam int PADDR_W  = ADDR_LSB + 1;

	// Multiplier consumes this many bits of the second operand per cycle
	localparam int MUL_CHUNK = 16;
	localparam int MUL_STEPS = (DATA_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int MUL_PAD_W = MUL_STEPS * MUL_CHUNK;

	localparam int CNT_W = $clog2(DATA_WIDTH);

	// Operation codes
	localparam logic [1:0] OP_SCALE = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_SET   = 2'd2;

	// Register indexes
	localparam logic REG_OUT_LOW  = 1'b0;
	localparam logic REG_OUT_HIGH = 1'b1;

	localparam logic signed [DATA_WIDTH-1:0] FIX_ONE = DATA_WIDTH'(65536);

	typedef struct packed {
		logic [1:0]                   operation;
		logic signed [DATA_WIDTH-1:0] value;
		logic signed [DATA_WIDTH-1:0] value_b;
	} req_word_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] scaled;
		logic signed [DATA_WIDTH-1:0] seen_lower;
		logic signed [DATA_WIDTH-1:0] seen_upper;
	} rsp_word_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] out_low;
		logic signed [DATA_WIDTH-1:0] out_high;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic setup;
		logic mul_step;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_scale;
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/ars_regs.sv =====
// APB register file holding the output range bounds.
`default_nettype none

module ars_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ars_pkg::PADDR_W-1:0] paddr,
	input  wire logic [ars_pkg::APB_DW-1:0]  pwdata,
	output logic      [ars_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output ars_pkg::cfg_t                    cfg
);

	localparam int W = ars_pkg::DATA_WIDTH;

	logic signed [W-1:0] out_low_q;
	logic signed [W-1:0] out_high_q;
	logic                wr_en;
	logic                reg_sel;

	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[ars_pkg::ADDR_LSB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_low_q  <= '0;
			out_high_q <= ars_pkg::FIX_ONE;
		end else if (wr_en) begin
			case (reg_sel)
				ars_pkg::REG_OUT_LOW:  out_low_q  <= pwdata[W-1:0];
				ars_pkg::REG_OUT_HIGH: out_high_q <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			ars_pkg::REG_OUT_LOW:  prdata = ars_pkg::APB_DW'(out_low_q);
			ars_pkg::REG_OUT_HIGH: prdata = ars_pkg::APB_DW'(out_high_q);
			default:               prdata = '0;
		endcase
	end

	assign pready       = 1'b1;
	assign cfg.out_low  = out_low_q;
	assign cfg.out_high = out_high_q;

endmodule

`default_nettype wire

// ===== hdl/ars_dp.sv =====
// Datapath: tracked range, shift-add multiplier and restoring divider.
`default_nettype none

module ars_dp (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ars_pkg::cmd_t           cmd,
	input  wire ars_pkg::req_word_t      req,
	input  wire ars_pkg::cfg_t           cfg,
	output ars_pkg::status_t             status,
	output ars_pkg::rsp_word_t           rsp
);

	localparam int W     = ars_pkg::DATA_WIDTH;
	localparam int ACC_W = 2 * W;
	localparam int CH    = ars_pkg::MUL_CHUNK;
	localparam int PAD_W = ars_pkg::MUL_PAD_W;

	function automatic logic [W-1:0] mag_w(input logic [W:0] v);
		logic [W:0] n;
		n = v[W] ? (~v + 1'b1) : v;
		return n[W-1:0];
	endfunction

	// Captured word
	logic [1:0]          op_q;
	logic signed [W-1:0] val_q;
	logic signed [W-1:0] valb_q;

	// Tracked range
	logic signed [W-1:0] min_q;
	logic signed [W-1:0] max_q;
	logic                primed_q;

	// Arithmetic operands
	logic [W-1:0]        a_q;
	logic [PAD_W-1:0]    b_q;
	logic [W-1:0]        d_q;
	logic signed [W-1:0] base_q;
	logic [ACC_W-1:0]    prod_q;

	ars_pkg::rsp_word_t  rsp_q;

	// Range update
	logic                prime_c;
	logic signed [W-1:0] lo_base_c;
	logic signed [W-1:0] hi_base_c;
	logic signed [W-1:0] new_min_c;
	logic signed [W-1:0] new_max_c;

	assign prime_c   = !primed_q && (min_q == max_q);
	assign lo_base_c = prime_c ? val_q : min_q;
	assign hi_base_c = prime_c ? val_q : max_q;
	assign new_min_c = (val_q < lo_base_c) ? val_q : lo_base_c;
	assign new_max_c = (val_q > hi_base_c) ? val_q : hi_base_c;

	// Operand setup
	logic                forward_c;
	logic signed [W-1:0] anchor_c;
	logic [W:0]          offset_c;
	logic [W:0]          span_in_c;
	logic [W:0]          span_out_c;

	assign forward_c  = cfg.out_low <= cfg.out_high;
	assign anchor_c   = forward_c ? min_q : max_q;
	assign offset_c   = {val_q[W-1], val_q} - {anchor_c[W-1], anchor_c};
	assign span_in_c  = {max_q[W-1], max_q} - {min_q[W-1], min_q};
	assign span_out_c = {cfg.out_high[W-1], cfg.out_high} - {cfg.out_low[W-1], cfg.out_low};

	// Multiply step: top chunk of b first
	logic [CH-1:0]       chunk_c;
	logic [W+CH-1:0]     pp_c;

	assign chunk_c = b_q[PAD_W-1 -: CH];
	assign pp_c    = {{CH{1'b0}}, a_q} * {{W{1'b0}}, chunk_c};

	// Divide step: remainder in the upper half, quotient shifts into the lower half
	logic [W:0]          trial_c;
	logic                take_c;
	logic [W:0]          diff_c;

	assign trial_c = {prod_q[ACC_W-1:W], prod_q[W-1]};
	assign take_c  = trial_c >= {1'b0, d_q};
	assign diff_c  = trial_c - {1'b0, d_q};

	// Result
	logic signed [W-1:0] scaled_c;
	logic                sorted_c;

	always_comb begin
		if (op_q != ars_pkg::OP_SCALE) begin
			scaled_c = '0;
		end else if (d_q == '0) begin
			scaled_c = base_q;
		end else begin
			scaled_c = base_q + prod_q[W-1:0];
		end
	end

	assign sorted_c = min_q <= max_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= req.operation;
			val_q  <= req.value;
			valb_q <= req.value_b;
		end
		if (cmd.setup) begin
			a_q    <= mag_w(offset_c);
			b_q    <= PAD_W'(mag_w(span_out_c));
			d_q    <= mag_w(span_in_c);
			base_q <= forward_c ? cfg.out_low : cfg.out_high;
			prod_q <= '0;
		end else if (cmd.mul_step) begin
			prod_q <= (prod_q << CH) + ACC_W'(pp_c);
			b_q    <= b_q << CH;
		end else if (cmd.div_step) begin
			prod_q <= {(take_c ? diff_c[W-1:0] : trial_c[W-1:0]), prod_q[W-2:0], take_c};
		end
		if (cmd.finish) begin
			rsp_q.scaled     <= scaled_c;
			rsp_q.seen_lower <= sorted_c ? min_q : max_q;
			rsp_q.seen_upper <= sorted_c ? max_q : min_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= '0;
			max_q    <= '0;
			primed_q <= 1'b0;
		end else if (cmd.update) begin
			case (op_q)
				ars_pkg::OP_SCALE: begin
					min_q    <= new_min_c;
					max_q    <= new_max_c;
					primed_q <= primed_q | prime_c;
				end
				ars_pkg::OP_CLEAR: begin
					min_q    <= '0;
					max_q    <= '0;
					primed_q <= 1'b0;
				end
				ars_pkg::OP_SET: begin
					min_q <= val_q;
					max_q <= valb_q;
				end
				default: ;
			endcase
		end
	end

	assign status.is_scale = op_q == ars_pkg::OP_SCALE;
	assign rsp             = rsp_q;

endmodule

`default_nettype wire

// ===== hdl/ars_ctrl.sv =====
// Controller: sequences capture, range update, multiply, divide and result hand-off.
`default_nettype none

`include "assert_macros.svh"

module ars_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	input  wire ars_pkg::status_t  status,
	output ars_pkg::cmd_t          cmd
);

	localparam int CW = ars_pkg::CNT_W;
	localparam logic [CW-1:0] MUL_LAST = CW'(ars_pkg::MUL_STEPS - 1);

	ars_pkg::state_t state_q;
	ars_pkg::state_t state_nxt;
	logic [CW-1:0]   cnt_q;
	logic            rsp_valid_q;
	logic            cnt_zero;
	logic            slot_free;
	logic            in_idle;
	logic            in_setup;
	logic            in_mul;
	logic            in_div;
	logic            in_done;

	assign cnt_zero  = cnt_q == '0;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign in_idle   = state_q == ars_pkg::ST_IDLE;
	assign in_setup  = state_q == ars_pkg::ST_SETUP;
	assign in_mul    = state_q == ars_pkg::ST_MUL;
	assign in_div    = state_q == ars_pkg::ST_DIV;
	assign in_done   = state_q == ars_pkg::ST_DONE;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ars_pkg::ST_IDLE:  if (req_valid) state_nxt = ars_pkg::ST_PREP;
			ars_pkg::ST_PREP:  state_nxt = status.is_scale ? ars_pkg::ST_SETUP : ars_pkg::ST_DONE;
			ars_pkg::ST_SETUP: state_nxt = ars_pkg::ST_MUL;
			ars_pkg::ST_MUL:   if (cnt_zero) state_nxt = ars_pkg::ST_DIV;
			ars_pkg::ST_DIV:   if (cnt_zero) state_nxt = ars_pkg::ST_DONE;
			ars_pkg::ST_DONE:  if (slot_free) state_nxt = ars_pkg::ST_IDLE;
			default:           state_nxt = ars_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		cmd          = '0;
		case (state_q)
			ars_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ars_pkg::ST_PREP:  cmd.update   = 1'b1;
			ars_pkg::ST_SETUP: cmd.setup    = 1'b1;
			ars_pkg::ST_MUL:   cmd.mul_step = 1'b1;
			ars_pkg::ST_DIV:   cmd.div_step = 1'b1;
			ars_pkg::ST_DONE:  cmd.finish   = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ars_pkg::ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rsp_valid_q <= cmd.finish | (rsp_valid_q & !rsp_ready);
			case (state_q)
				ars_pkg::ST_SETUP: cnt_q <= MUL_LAST;
				ars_pkg::ST_MUL:   cnt_q <= cnt_zero ? CW'(ars_pkg::DATA_WIDTH - 1) : cnt_q - 1'b1;
				ars_pkg::ST_DIV:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;

	`ASSERT_NXT(a_mul_loaded, clk, arst_n, in_setup, in_mul && cnt_q == MUL_LAST)
	`ASSERT_NXT(a_div_ends, clk, arst_n, in_div && cnt_zero, in_done)
	`ASSERT_NXT(a_finish_shows, clk, arst_n, cmd.finish, rsp_valid_q && in_idle)
	`ASSERT_NXT(a_done_waits, clk, arst_n, in_done && rsp_valid_q && !rsp_ready, in_done)

endmodule

`default_nettype wire

// ===== hdl/auto_range_scaler.sv =====
// Top level of the auto range scaler: register file, controller and datapath.
`default_nettype none

// Running min/max normalizer for signed Q16.16 words. A scale word widens the
// tracked range and maps the sample linearly onto [out_low, out_high] (reversed
// when out_low is above out_high), quotient truncated toward zero; clear and set
// words adjust the range and return scaled = 0. One word is in flight at a time.
// A scale word passes through capture, range update and operand setup, then a
// 16-bit-per-cycle shift-add multiplier and a one-bit-per-cycle restoring divider,
// before its result registers. Clear, set and unused codes skip the multiply and
// divide. The block is ready again the cycle after the result registers, so a new
// scale word is taken only once the previous one has finished.
// The next word is taken while a finished result still waits in the output register.
// Registers out_low (reset 0.0) and out_high (reset 1.0) sit on the APB port; the user
// must write them only while the block is idle, as the block does not enforce this.
module auto_range_scaler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire ars_pkg::req_word_t          req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output ars_pkg::rsp_word_t               rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ars_pkg::PADDR_W-1:0] paddr,
	input  wire logic [ars_pkg::APB_DW-1:0]  pwdata,
	output logic      [ars_pkg::APB_DW-1:0]  prdata,
	output logic                             pready
);

	ars_pkg::cfg_t    cfg;
	ars_pkg::cmd_t    cmd;
	ars_pkg::status_t status;

	ars_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ars_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ars_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.cfg    (cfg),
		.status (status),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
